[hw/rtl/cone_distance_truncated_score_defines.svh]
// Assertion helpers used by the cone scorer back end (cdts_back).
`ifndef CONE_DISTANCE_TRUNCATED_SCORE_DEFINES_SVH
`define CONE_DISTANCE_TRUNCATED_SCORE_DEFINES_SVH
// same-cycle implication
`define CDTS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// next-cycle implication
`define CDTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`endif

[hw/rtl/cdts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdts_pkg
// Types and constants of the cone distance scorer.
// ----------------------------------------------------------------------------
package cdts_pkg;

  localparam int unsigned MAX_POINTS = 65536;
  localparam logic [16:0] INLIER_CAP =
    (MAX_POINTS < 131071) ? 17'(MAX_POINTS) : 17'd131071;
  localparam logic signed [31:0] AXIS_ONE   = 32'sd1073741824;
  localparam logic signed [35:0] H_LIMIT    = 36'sd8589934591;
  localparam logic [33:0]        R_LIMIT    = 34'h3_FFFF_FFFF;
  localparam logic [31:0]        TAN_RESET  = 32'd16777216;
  localparam logic [31:0]        LIMIT_RESET = 32'd65536;

  typedef enum logic [2:0] {
    REG_APEX_X, REG_APEX_Y, REG_APEX_Z,
    REG_AXIS_X, REG_AXIS_Y, REG_AXIS_Z,
    REG_TAN_HALF_ANGLE, REG_ERROR_LIMIT
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               last_point;
  } in_t;

  typedef struct packed {
    logic [31:0] surface_distance;
    logic [63:0] squared_error;
    logic        is_inlier;
    logic [16:0] inlier_tally;
    logic [63:0] score;
    logic        last_result;
  } out_t;

  typedef struct packed {
    logic signed [33:0] v_x;
    logic signed [33:0] v_y;
    logic signed [33:0] v_z;
    logic               last;
  } vec_t;

  typedef struct packed {
    logic        busy;
    logic [31:0] arm_cosine;
    logic [31:0] arm_sine;
  } arm_t;

  typedef struct packed {
    logic signed [31:0] axis_x;
    logic signed [31:0] axis_y;
    logic signed [31:0] axis_z;
    logic [31:0]        arm_cosine;
    logic [31:0]        arm_sine;
    logic [31:0]        error_limit;
  } geom_t;

  typedef enum logic [2:0] {
    A_IDLE, A_SQ, A_SETUP, A_DIV, A_RSET, A_ROOT, A_SINE, A_FIN
  } arm_state_t;

  typedef enum logic [3:0] {
    B_IDLE, B_DOT, B_HSET, B_WPRD, B_WSQ, B_RSET, B_ROOT,
    B_AMUL, B_BMUL, B_SQE, B_LIM, B_OUT
  } back_state_t;

  function automatic logic signed [31:0] clamp_axis(input logic signed [31:0] a);
    if (a > AXIS_ONE) begin
      return AXIS_ONE;
    end else if (a < -AXIS_ONE) begin
      return -AXIS_ONE;
    end
    return a;
  endfunction

endpackage

[hw/rtl/cdts_arm.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdts_arm
// Derives cosine and sine of the cone half angle from its tangent.
// ----------------------------------------------------------------------------
module cdts_arm import cdts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] tan_half_angle,
  output arm_t        arm
);

  arm_state_t  state, state_next;
  logic [6:0]  cnt;
  logic [63:0] mp;
  logic [31:0] mul_b;
  logic [62:0] d;
  logic [62:0] rem;
  logic [63:0] rem2;
  logic [63:0] q;
  logic [63:0] sqin;
  logic [33:0] srem;
  logic [35:0] srem2;
  logic [35:0] trial;
  logic [31:0] root;
  logic [31:0] cosine;
  logic [31:0] sine;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_SQ;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      A_IDLE:  state_next = A_IDLE;
      A_SQ:    state_next = A_SETUP;
      A_SETUP: state_next = A_DIV;
      A_DIV:   if (cnt == '0) state_next = A_RSET;
      A_RSET:  state_next = A_ROOT;
      A_ROOT:  if (cnt == '0) state_next = A_SINE;
      A_SINE:  state_next = A_FIN;
      A_FIN:   state_next = A_IDLE;
      default: state_next = A_IDLE;
    endcase
    if (start) state_next = A_SQ;
  end

  always_comb begin
    mul_b = (state == A_SINE) ? root : tan_half_angle;
    arm.busy = (state != A_IDLE);
    arm.arm_cosine = cosine;
    arm.arm_sine = sine;
  end

  assign rem2  = {rem, (cnt == 7'd106)};
  assign srem2 = {srem, sqin[63:62]};
  assign trial = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    mp <= 64'(tan_half_angle) * 64'(mul_b);
    unique case (state)
      A_SETUP: begin
        d   <= 63'(64'h4000_0000_0000 + (mp >> 2));
        rem <= '0;
        q   <= '0;
        cnt <= 7'd106;
      end
      A_DIV: begin
        if (rem2 >= {1'b0, d}) begin
          rem <= 63'(rem2 - {1'b0, d});
          q   <= {q[62:0], 1'b1};
        end else begin
          rem <= rem2[62:0];
          q   <= {q[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
      end
      A_RSET: begin
        sqin <= q;
        srem <= '0;
        root <= '0;
        cnt  <= 7'd31;
      end
      A_ROOT: begin
        if (srem2 >= trial) begin
          srem <= 34'(srem2 - trial);
          root <= {root[30:0], 1'b1};
        end else begin
          srem <= srem2[33:0];
          root <= {root[30:0], 1'b0};
        end
        sqin <= {sqin[61:0], 2'b00};
        cnt  <= cnt - 7'd1;
      end
      A_FIN: begin
        cosine <= root;
        sine   <= mp[55:24];
      end
      default: ;
    endcase
  end

endmodule

[hw/rtl/cdts_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdts_queue
// Two-word queue between the front and the back.
// ----------------------------------------------------------------------------
module cdts_queue import cdts_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  vec_t wdata,
  output logic full,
  input  logic rd,
  output vec_t rdata,
  output logic nonempty
);

  vec_t       mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign nonempty = (count != 2'd0);
  assign rdata    = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (wr) wptr <= ~wptr;
      if (rd) rptr <= ~rptr;
      count <= count + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wptr] <= wdata;
  end

endmodule

[hw/rtl/cdts_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdts_front
// Configuration registers, point intake and apex offset.
// ----------------------------------------------------------------------------
module cdts_front import cdts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  in_t         point,
  input  logic        q_full,
  output logic        q_push,
  output vec_t        q_data,
  input  arm_t        arm,
  output logic        arm_start,
  output logic [31:0] tan_half_angle,
  output geom_t       geom
);

  logic signed [31:0] apex_x, apex_y, apex_z;
  logic signed [31:0] axis_x, axis_y, axis_z;
  logic [31:0]        error_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      apex_x <= '0;
      apex_y <= '0;
      apex_z <= '0;
      axis_x <= '0;
      axis_y <= '0;
      axis_z <= AXIS_ONE;
      tan_half_angle <= TAN_RESET;
      error_limit <= LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_APEX_X:         apex_x <= cfg_data;
        REG_APEX_Y:         apex_y <= cfg_data;
        REG_APEX_Z:         apex_z <= cfg_data;
        REG_AXIS_X:         axis_x <= clamp_axis(cfg_data);
        REG_AXIS_Y:         axis_y <= clamp_axis(cfg_data);
        REG_AXIS_Z:         axis_z <= clamp_axis(cfg_data);
        REG_TAN_HALF_ANGLE: tan_half_angle <= cfg_data;
        REG_ERROR_LIMIT:    error_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  assign arm_start = cfg_write && (reg_idx_t'(cfg_index) == REG_TAN_HALF_ANGLE);
  assign full      = q_full || arm.busy;
  assign q_push    = push && !full;

  always_comb begin
    q_data.v_x  = 34'(point.point_x) - 34'(apex_x);
    q_data.v_y  = 34'(point.point_y) - 34'(apex_y);
    q_data.v_z  = 34'(point.point_z) - 34'(apex_z);
    q_data.last = point.last_point;
    geom.axis_x = axis_x;
    geom.axis_y = axis_y;
    geom.axis_z = axis_z;
    geom.arm_cosine  = arm.arm_cosine;
    geom.arm_sine    = arm.arm_sine;
    geom.error_limit = error_limit;
  end

endmodule

[hw/rtl/cdts_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdts_back
// Per-point distance sequencer, running totals and result register.
// ----------------------------------------------------------------------------
`include "cone_distance_truncated_score_defines.svh"
module cdts_back import cdts_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  q_nonempty,
  input  vec_t  q_data,
  output logic  q_pop,
  input  geom_t geom,
  output logic  empty,
  input  logic  pop,
  output out_t  result
);

  back_state_t        state, state_next;
  logic               ph;
  logic [1:0]         idx;
  logic [5:0]         cnt;
  logic signed [33:0] v [3];
  logic signed [31:0] ax [3];
  logic               last;
  logic signed [36:0] mul_a, mul_b;
  logic signed [73:0] mp;
  logic signed [65:0] acc;
  logic signed [35:0] h_full;
  logic signed [35:0] h;
  logic [33:0]        hs;
  logic signed [35:0] w_cur;
  logic signed [36:0] w_calc;
  logic [71:0]        wacc;
  logic [71:0]        sqin;
  logic [37:0]        srem;
  logic [39:0]        srem2;
  logic [39:0]        trial;
  logic [35:0]        root;
  logic [33:0]        r_sat;
  logic [63:0]        a_p;
  logic [63:0]        b_p;
  logic [63:0]        diff;
  logic [33:0]        surf_dist;
  logic               far;
  logic [63:0]        sq;
  logic [63:0]        lim;
  logic               inl;
  logic [16:0]        inlier_total, count_new;
  logic [63:0]        score_total, score_new;
  logic [64:0]        score_sum;
  logic               res_valid;
  logic               res_write;
  out_t               res;

  assign ax[0] = geom.axis_x;
  assign ax[1] = geom.axis_y;
  assign ax[2] = geom.axis_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: if (q_nonempty) state_next = B_DOT;
      B_DOT:  if (ph && idx == 2'd2) state_next = B_HSET;
      B_HSET: state_next = B_WPRD;
      B_WPRD: if (ph) state_next = B_WSQ;
      B_WSQ:  if (ph) state_next = (idx == 2'd2) ? B_RSET : B_WPRD;
      B_RSET: state_next = B_ROOT;
      B_ROOT: if (cnt == '0) state_next = B_AMUL;
      B_AMUL: if (ph) state_next = B_BMUL;
      B_BMUL: if (ph) state_next = B_SQE;
      B_SQE:  if (ph) state_next = B_LIM;
      B_LIM:  if (ph) state_next = B_OUT;
      B_OUT:  if (!res_valid || pop) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    res_write = 1'b0;
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      B_IDLE: q_pop = q_nonempty;
      B_DOT: begin
        mul_a = 37'(v[idx]);
        mul_b = 37'(ax[idx]);
      end
      B_WPRD: begin
        mul_a = 37'(h);
        mul_b = 37'(ax[idx]);
      end
      B_WSQ: begin
        mul_a = 37'(w_cur);
        mul_b = 37'(w_cur);
      end
      B_AMUL: begin
        mul_a = $signed({3'b000, hs});
        mul_b = $signed({5'b00000, geom.arm_sine});
      end
      B_BMUL: begin
        mul_a = $signed({3'b000, r_sat});
        mul_b = $signed({5'b00000, geom.arm_cosine});
      end
      B_SQE: begin
        mul_a = $signed({5'b00000, surf_dist[31:0]});
        mul_b = $signed({5'b00000, surf_dist[31:0]});
      end
      B_LIM: begin
        mul_a = $signed({5'b00000, geom.error_limit});
        mul_b = $signed({5'b00000, geom.error_limit});
      end
      B_OUT: res_write = !res_valid || pop;
      default: ;
    endcase
  end

  assign h_full = acc[65:30];
  assign hs     = h[35] ? 34'(-h) : h[33:0];
  assign w_calc = 37'(v[idx]) - $signed(mp[66:30]);
  assign srem2  = {srem, sqin[71:70]};
  assign trial  = {2'b00, root, 2'b01};
  assign r_sat  = (root > 36'(R_LIMIT)) ? R_LIMIT : root[33:0];
  assign b_p    = mp[63:0];
  assign diff   = (a_p > b_p) ? a_p - b_p : b_p - a_p;
  assign far    = |surf_dist[33:32];

  assign inl       = sq < lim;
  assign count_new = (inl && inlier_total < INLIER_CAP) ? inlier_total + 17'd1 : inlier_total;
  assign score_sum = {1'b0, score_total} + {1'b0, inl ? sq : lim};
  assign score_new = score_sum[64] ? '1 : score_sum[63:0];

  always_ff @(posedge clk) begin
    mp <= mul_a * mul_b;
    unique case (state)
      B_IDLE: begin
        v[0] <= q_data.v_x;
        v[1] <= q_data.v_y;
        v[2] <= q_data.v_z;
        last <= q_data.last;
        acc  <= '0;
        wacc <= '0;
        idx  <= '0;
        ph   <= 1'b0;
      end
      B_DOT: begin
        ph <= ~ph;
        if (ph) begin
          acc <= acc + 66'(mp);
          idx <= idx + 2'd1;
        end
      end
      B_HSET: begin
        idx <= '0;
        if (h_full > H_LIMIT) begin
          h <= H_LIMIT;
        end else if (h_full < -H_LIMIT) begin
          h <= -H_LIMIT;
        end else begin
          h <= h_full;
        end
      end
      B_WPRD: begin
        ph <= ~ph;
        if (ph) w_cur <= 36'(w_calc);
      end
      B_WSQ: begin
        ph <= ~ph;
        if (ph) begin
          wacc <= wacc + mp[71:0];
          idx  <= idx + 2'd1;
        end
      end
      B_RSET: begin
        sqin <= wacc;
        srem <= '0;
        root <= '0;
        cnt  <= 6'd35;
      end
      B_ROOT: begin
        if (srem2 >= trial) begin
          srem <= 38'(srem2 - trial);
          root <= {root[34:0], 1'b1};
        end else begin
          srem <= srem2[37:0];
          root <= {root[34:0], 1'b0};
        end
        sqin <= {sqin[69:0], 2'b00};
        cnt  <= cnt - 6'd1;
      end
      B_AMUL: begin
        ph <= ~ph;
        if (ph) a_p <= mp[63:0];
      end
      B_BMUL: begin
        ph <= ~ph;
        if (ph) surf_dist <= diff[63:30];
      end
      B_SQE: begin
        ph <= ~ph;
        if (ph) sq <= far ? '1 : mp[63:0];
      end
      B_LIM: begin
        ph <= ~ph;
        if (ph) lim <= mp[63:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid    <= 1'b0;
      inlier_total <= '0;
      score_total  <= '0;
    end else begin
      if (res_write) begin
        res_valid    <= 1'b1;
        inlier_total <= last ? '0 : count_new;
        score_total  <= last ? '0 : score_new;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_write) begin
      res.surface_distance <= far ? '1 : surf_dist[31:0];
      res.squared_error    <= sq;
      res.is_inlier        <= inl;
      res.inlier_tally     <= count_new;
      res.score            <= score_new;
      res.last_result      <= last;
    end
  end

  assign empty  = !res_valid;
  assign result = res;

  `CDTS_ASSERT_IMPL(a_count_capped, clk, rst, res_valid, res.inlier_tally <= INLIER_CAP)
  `CDTS_ASSERT_IMPL(a_far_not_inlier, clk, rst, res_valid && res.squared_error == '1, !res.is_inlier)
  `CDTS_ASSERT_NEXT(a_totals_cleared, clk, rst, res_write && last, inlier_total == '0 && score_total == '0)

endmodule

[hw/rtl/cone_distance_truncated_score.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cone_distance_truncated_score
// Cone hypothesis scorer with truncated squared error over a point stream.
// ----------------------------------------------------------------------------
// In the back end, one shared 37x37 multiplier serves thirteen products per
// point in turn, and a radial square root runs one result bit per cycle. A
// two-word queue lets the front take points while the back works. After reset
// and after every write of tan_half_angle, full stays high while the arm cosine
// and sine are derived (a 107-step divider and a 32-step square root).
module cone_distance_truncated_score import cdts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  in_t         point,
  output logic        empty,
  input  logic        pop,
  output out_t        result
);

  logic        q_full, q_push, q_pop, q_nonempty;
  vec_t        q_wdata, q_rdata;
  arm_t        arm;
  logic        arm_start;
  logic [31:0] tan_half_angle;
  geom_t       geom;

  cdts_front u_front (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .push, .full, .point,
    .q_full, .q_push, .q_data(q_wdata),
    .arm, .arm_start, .tan_half_angle, .geom
  );

  cdts_arm u_arm (
    .clk, .rst, .start(arm_start), .tan_half_angle, .arm
  );

  cdts_queue u_queue (
    .clk, .rst, .wr(q_push), .wdata(q_wdata), .full(q_full),
    .rd(q_pop), .rdata(q_rdata), .nonempty(q_nonempty)
  );

  cdts_back u_back (
    .clk, .rst, .q_nonempty, .q_data(q_rdata), .q_pop,
    .geom, .empty, .pop, .result
  );

endmodule
